@@ src/shs_pkg.sv @@
// ----------------------------------------------------------------------------
// shs_pkg: shared types and constants of the SHA-512 stream hasher
// Beat types, the classified entry kind, round constants and the
// SHA-512 mixing functions.
// ----------------------------------------------------------------------------
package shs_pkg;

	localparam int ROUNDS = 80;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last_item;
	} shs_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        error;
	} shs_result_t;

	typedef enum logic [1:0] {
		KIND_ERR,
		KIND_WORD,
		KIND_WORD_LAST,
		KIND_SHORT_LAST
	} shs_kind_t;

	typedef struct packed {
		shs_kind_t   kind;
		logic [63:0] word;
		logic [3:0]  count;
	} shs_entry_t;

	localparam logic [63:0] PAD_MARK = 64'h8000_0000_0000_0000;

	localparam logic [63:0] IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] RK [ROUNDS] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic logic [63:0] big_s0(input logic [63:0] x);
		return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
	endfunction

	function automatic logic [63:0] big_s1(input logic [63:0] x);
		return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
	endfunction

	function automatic logic [63:0] small_s0(input logic [63:0] x);
		return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
	endfunction

	function automatic logic [63:0] small_s1(input logic [63:0] x);
		return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
	endfunction

endpackage

@@ src/shs_fifo.sv @@
// ----------------------------------------------------------------------------
// shs_fifo: small register queue
// Holds up to DEPTH entries of WIDTH bits and shows the oldest one.
// ----------------------------------------------------------------------------
module shs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

@@ src/shs_front.sv @@
// ----------------------------------------------------------------------------
// shs_front: input classifier
// Saturates the byte count, sorts each beat by kind and builds the
// padded word for a short final beat.
// ----------------------------------------------------------------------------
module shs_front (
	input  shs_pkg::shs_item_t  item,
	output shs_pkg::shs_entry_t entry
);
	import shs_pkg::*;

	logic [3:0] cnt;
	logic [5:0] shamt;
	logic [63:0] mask;

	always_comb begin
		cnt   = (item.byte_count > 4'd8) ? 4'd8 : item.byte_count;
		shamt = {cnt[2:0], 3'b000};
		mask  = ~({64{1'b1}} >> shamt);
		entry.count = cnt;
		entry.word  = item.data_word;
		if (cnt == 4'd8) begin
			entry.kind = item.last_item ? KIND_WORD_LAST : KIND_WORD;
		end else if (item.last_item) begin
			entry.kind = KIND_SHORT_LAST;
			entry.word = (item.data_word & mask) | (PAD_MARK >> shamt);
		end else begin
			entry.kind = KIND_ERR;
		end
	end

endmodule

@@ src/shs_core.sv @@
// ----------------------------------------------------------------------------
// shs_core: SHA-512 compression engine
// Fills the block buffer, runs one round per cycle, pads the final
// block and emits the digest one word per beat.
// ----------------------------------------------------------------------------
module shs_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shs_pkg::shs_entry_t  q_data,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  logic                 o_full,
	output logic                 o_push,
	output shs_pkg::shs_result_t o_data
);
	import shs_pkg::*;

	localparam int RW = $clog2(ROUNDS);
	localparam logic [RW-1:0] LAST_RND = RW'(ROUNDS - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_PAD, S_LEN, S_CMP, S_FIN, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		R_IDLE, R_PAD, R_LEN, R_OUT
	} ret_t;

	state_t      state_q;
	ret_t        ret_q;
	logic [63:0] hash_q [8];
	logic [63:0] wv_q [8];
	logic [63:0] win_q [16];
	logic [3:0]  widx_q;
	logic [63:0] len_hi_q, len_lo_q;
	logic [63:0] pad_q;
	logic [RW-1:0] rnd_q;
	logic [2:0]  oidx_q;

	logic [63:0] t1, t2, wnext, add_len;
	logic [64:0] len_sum;

	always_comb begin
		q_pop  = 1'b0;
		o_push = 1'b0;
		o_data = '{digest_word: hash_q[oidx_q], word_index: oidx_q,
			last_word: (oidx_q == 3'd7), error: 1'b0};
		if (state_q == S_IDLE && !q_empty) begin
			if (q_data.kind == KIND_ERR) begin
				o_data = '{digest_word: '0, word_index: '0, last_word: 1'b1, error: 1'b1};
				q_pop  = !o_full;
				o_push = !o_full;
			end else begin
				q_pop = 1'b1;
			end
		end else if (state_q == S_OUT) begin
			o_push = !o_full;
		end
	end

	always_comb begin
		t1 = wv_q[7] + big_s1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
			+ RK[rnd_q] + win_q[0];
		t2 = big_s0(wv_q[0]) + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2])
			^ (wv_q[1] & wv_q[2]));
		wnext   = small_s1(win_q[14]) + win_q[9] + small_s0(win_q[1]) + win_q[0];
		add_len = {57'd0, q_data.count, 3'b000};
		len_sum = {1'b0, len_lo_q} + {1'b0, add_len};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= R_IDLE;
			hash_q   <= IV;
			widx_q   <= '0;
			len_hi_q <= '0;
			len_lo_q <= '0;
			pad_q    <= '0;
			rnd_q    <= '0;
			oidx_q   <= '0;
			wv_q     <= '{default: '0};
			win_q    <= '{default: '0};
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_pop && q_data.kind != KIND_ERR) begin
						len_lo_q <= len_sum[63:0];
						len_hi_q <= len_hi_q + {63'd0, len_sum[64]};
						rnd_q    <= '0;
						wv_q     <= hash_q;
						unique case (q_data.kind)
							KIND_WORD: begin
								win_q[widx_q] <= q_data.word;
								widx_q <= widx_q + 1'b1;
								if (widx_q == 4'd15) begin
									ret_q   <= R_IDLE;
									state_q <= S_CMP;
								end
							end
							KIND_WORD_LAST: begin
								win_q[widx_q] <= q_data.word;
								widx_q <= widx_q + 1'b1;
								pad_q  <= PAD_MARK;
								if (widx_q == 4'd15) begin
									ret_q   <= R_PAD;
									state_q <= S_CMP;
								end else begin
									state_q <= S_PAD;
								end
							end
							default: begin
								pad_q   <= q_data.word;
								state_q <= S_PAD;
							end
						endcase
					end
				end
				S_PAD: begin
					for (int k = 0; k < 16; k++) begin
						if (4'(k) == widx_q) begin
							win_q[k] <= pad_q;
						end else if (4'(k) > widx_q) begin
							win_q[k] <= '0;
						end
					end
					if (widx_q < 4'd14) begin
						win_q[14] <= len_hi_q;
						win_q[15] <= len_lo_q;
						ret_q <= R_OUT;
					end else begin
						ret_q <= R_LEN;
					end
					rnd_q   <= '0;
					wv_q    <= hash_q;
					state_q <= S_CMP;
				end
				S_LEN: begin
					for (int k = 0; k < 14; k++) begin
						win_q[k] <= '0;
					end
					win_q[14] <= len_hi_q;
					win_q[15] <= len_lo_q;
					ret_q   <= R_OUT;
					rnd_q   <= '0;
					wv_q    <= hash_q;
					state_q <= S_CMP;
				end
				S_CMP: begin
					wv_q[7] <= wv_q[6];
					wv_q[6] <= wv_q[5];
					wv_q[5] <= wv_q[4];
					wv_q[4] <= wv_q[3] + t1;
					wv_q[3] <= wv_q[2];
					wv_q[2] <= wv_q[1];
					wv_q[1] <= wv_q[0];
					wv_q[0] <= t1 + t2;
					for (int k = 0; k < 15; k++) begin
						win_q[k] <= win_q[k+1];
					end
					win_q[15] <= wnext;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == LAST_RND) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					for (int k = 0; k < 8; k++) begin
						hash_q[k] <= hash_q[k] + wv_q[k];
					end
					oidx_q <= '0;
					unique case (ret_q)
						R_IDLE:  state_q <= S_IDLE;
						R_PAD:   state_q <= S_PAD;
						R_LEN:   state_q <= S_LEN;
						default: state_q <= S_OUT;
					endcase
				end
				default: begin
					if (o_push) begin
						oidx_q <= oidx_q + 1'b1;
						if (oidx_q == 3'd7) begin
							hash_q   <= IV;
							len_hi_q <= '0;
							len_lo_q <= '0;
							widx_q   <= '0;
							state_q  <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

endmodule

@@ src/sha512_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha512_stream_hasher: SHA-512 over a stream of 64-bit message words
//
// Input beats (push/full) carry one big-endian word, its valid byte count
// and an end-of-message mark. Only the final beat may be short; a short
// beat without the mark is dropped and answered with one error result.
// A front classifier writes each beat into a small queue, so the input
// takes one beat per cycle until that queue fills.
// The compression engine takes full words into its block buffer while idle.
// The sixteenth word of a block also loads the working variables and is
// followed by the 80 rounds and the final add, during which no new word is
// taken, so a long message is paced by the one-round-per-cycle datapath.
// The final beat costs the padding state, one or two compressions and
// eight digest beats, one per cycle while the receiver pops. Padding
// spills into a second block, filled in the length state, when the padding
// word lands in word 14 or 15 of the block.
// Results (empty/pop) leave through a queue; when the receiver stalls it
// fills, the engine holds and then the input queue fills too.
// After reset, and after each digest, the hash state is the standard
// initial value and the length and fill level are zero.
// ----------------------------------------------------------------------------
module sha512_stream_hasher #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  shs_pkg::shs_item_t   item,
	output logic                 empty,
	input  logic                 pop,
	output shs_pkg::shs_result_t result
);
	import shs_pkg::*;

	shs_entry_t  entry_in, entry_out;
	shs_result_t res_in;
	logic        q_empty, q_pop, o_full, o_push;

	shs_front u_front (
		.item  (item),
		.entry (entry_in)
	);

	shs_fifo #(.WIDTH($bits(shs_entry_t)), .DEPTH(QUEUE_DEPTH)) u_in_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (entry_in),
		.full  (full),
		.pop   (q_pop),
		.rdata (entry_out),
		.empty (q_empty)
	);

	shs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (entry_out),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.o_full (o_full),
		.o_push (o_push),
		.o_data (res_in)
	);

	shs_fifo #(.WIDTH($bits(shs_result_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (o_push),
		.wdata (res_in),
		.full  (o_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("engine popped an empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(o_push && o_full))
		else $error("engine pushed into a full result queue");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.error) |-> (result.last_word && result.word_index == 3'd0))
		else $error("error result malformed");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.last_word && !result.error) |-> (result.word_index == 3'd7))
		else $error("final digest beat not at index seven");

endmodule

@@ bench/sha512_stream_hasher_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_stream_hasher_check: digest predictor and result checker
// Watches the input and result queues of the hasher. Every accepted input
// beat is run through a SHA-512 model of its own; the digest words or the
// error result it yields are queued and compared with each popped beat.
// ----------------------------------------------------------------------------
module sha512_stream_hasher_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  shs_pkg::shs_item_t   item,
	input  logic                 empty,
	input  logic                 pop,
	input  shs_pkg::shs_result_t result,
	output int                   failures,
	output int                   pending
);
	import shs_pkg::*;

	logic [63:0] chain [8];
	logic [63:0] window [16];
	int unsigned fill_bytes;
	logic [127:0] msg_bits;
	shs_result_t digest_queue [$];

	assign pending = digest_queue.size();

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic compress();
		logic [63:0] v [8];
		logic [63:0] w, t1, t2, a, e, x2, x15;
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int t = 0; t < ROUNDS; t++) begin
			if (t < 16) begin
				w = window[t];
			end else begin
				x2 = window[(t - 2) & 15];
				x15 = window[(t - 15) & 15];
				w = (rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6)) + window[(t - 7) & 15]
					+ (rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7)) + window[t & 15];
				window[t & 15] = w;
			end
			a = v[0];
			e = v[4];
			t1 = v[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
				+ ((e & v[5]) ^ (~e & v[6])) + RK[t] + w;
			t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
				+ ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] += v[i];
	endtask

	task automatic clear_message();
		for (int i = 0; i < 8; i++) chain[i] = IV[i];
		fill_bytes = 0;
		msg_bits = '0;
	endtask

	task automatic absorb(input shs_item_t it);
		int unsigned cnt, idx;
		logic [63:0] word, mask;
		shs_result_t r;
		cnt = (it.byte_count > 8) ? 8 : it.byte_count;
		if (cnt < 8 && !it.last_item) begin
			r = '{digest_word: '0, word_index: '0, last_word: 1'b1, error: 1'b1};
			digest_queue.push_back(r);
			return;
		end
		msg_bits += 128'(cnt * 8);
		idx = fill_bytes / 8;
		if (cnt == 8) begin
			window[idx] = it.data_word;
			fill_bytes += 8;
			if (fill_bytes >= 128) begin
				compress();
				fill_bytes = 0;
			end
			if (!it.last_item) return;
			idx = fill_bytes / 8;
			word = PAD_MARK;
		end else begin
			mask = (cnt == 0) ? '0 : ~64'h0 << (64 - 8 * cnt);
			word = (it.data_word & mask) | (PAD_MARK >> (8 * cnt));
		end
		window[idx] = word;
		for (int k = idx + 1; k < 16; k++) window[k] = '0;
		if (idx >= 14) begin
			compress();
			for (int k = 0; k < 14; k++) window[k] = '0;
		end
		window[14] = msg_bits[127:64];
		window[15] = msg_bits[63:0];
		compress();
		for (int k = 0; k < 8; k++) begin
			r = '{digest_word: chain[k], word_index: 3'(k), last_word: k == 7, error: 1'b0};
			digest_queue.push_back(r);
		end
		clear_message();
	endtask

	initial begin
		failures = 0;
		clear_message();
	end

	always @(posedge clk) begin
		shs_result_t want;
		if (arst_n && pop && !empty) begin
			if (digest_queue.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, result);
				failures++;
			end else begin
				want = digest_queue.pop_front();
				if (result.digest_word !== want.digest_word || result.word_index !== want.word_index
					|| result.last_word !== want.last_word || result.error !== want.error) begin
					$display("%0t: mismatch expected %h/%0d/%b/%b actual %h/%0d/%b/%b", $time,
						want.digest_word, want.word_index, want.last_word, want.error,
						result.digest_word, result.word_index, result.last_word, result.error);
					failures++;
				end
			end
		end
		if (arst_n && push && !full) absorb(item);
	end
endmodule

@@ bench/sha512_stream_hasher_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_stream_hasher_test: stimulus and verdict for the stream hasher
// Sends directed messages covering empty, short, padded-over-block and
// error beats, then random messages of mostly small size with random gaps
// and receiver stalls, including a long result stall and a full drain.
// ----------------------------------------------------------------------------
module sha512_stream_hasher_test;
	import shs_pkg::*;

	logic clk, arst_n, push, full, empty, pop;
	shs_item_t item;
	shs_result_t result;
	int failures, pending;
	bit quiet, hold_results;

	sha512_stream_hasher dut (.*);
	sha512_stream_hasher_check checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("sha512_stream_hasher test failed");
		$finish;
	end

	task automatic send(input logic [63:0] d, input int cnt, input bit last);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		push <= 1;
		item <= '{data_word: d, byte_count: 4'(cnt), last_item: last};
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic send_message(input int words);
		logic [63:0] d;
		for (int i = 0; i < words; i++) begin
			d = {$urandom, $urandom};
			send(d, 8, 0);
		end
		d = {$urandom, $urandom};
		send(d, $urandom_range(0, 9) == 9 ? $urandom_range(8, 15) : $urandom_range(0, 8), 1);
	endtask

	initial begin
		int sent;
		push = 0; pop = 0; item = '0; quiet = 0; hold_results = 0;
		arst_n = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		send(64'h0, 0, 1);
		send(64'h6162_6300_0000_0000, 3, 1);
		send(~64'h0, 8, 1);
		send(~64'h0, 7, 0);
		send(64'h0, 0, 0);
		send(~64'h0, 15, 1);
		for (int i = 0; i < 13; i++) send(~64'h0, 8, 0);
		send(~64'h0, 7, 1);
		for (int i = 0; i < 14; i++) send(64'h0, 8, 0);
		send(64'h1, 8, 1);
		hold_results = 1;
		send_message(20);
		hold_results = 0;
		push <= 0;
		wait (pending == 0);
		sent = 0;
		while (sent < 440) begin
			int words;
			if (sent > 370) quiet = 1;
			if ($urandom_range(0, 7) == 0) begin
				send({$urandom, $urandom}, $urandom_range(0, 7), 0);
				sent++;
			end else begin
				words = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 40)
					: $urandom_range(0, 17);
				send_message(words);
				sent += words + 1;
			end
		end
		push <= 0;
		fork : drain
			wait (pending == 0);
			repeat (100000) @(posedge clk);
		join_any
		disable drain;
		repeat (200) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("sha512_stream_hasher test passed");
		end else begin
			$display("sha512_stream_hasher test failed");
		end
		$finish;
	end

	initial begin
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_results && !held) begin
				held = 1;
				pop <= 0;
				repeat (300) @(negedge clk);
			end
			if (!quiet && $urandom_range(0, 4) == 0) begin
				pop <= 0;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				pop <= 1;
			end
		end
	end
endmodule
